/* sv/length_prefixed_frame_receiver_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame receiver
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define LPFR_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("lpfr assertion failed");

// Check that expr never holds outside reset.
`define LPFR_NEVER(lbl, clk_s, rst_n_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(expr)) \
		else $error("lpfr forbidden condition seen");

`else

`define LPFR_ASSERT(lbl, clk_s, rst_n_s, prop)
`define LPFR_NEVER(lbl, clk_s, rst_n_s, expr)

`endif

`endif

/* sv/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

	localparam int HEADER_FIELD_BYTES_DEF = 8;
	localparam int LENGTH_BITS_DEF        = 32;

	localparam int BYTE_W    = 8;
	localparam int PHASE_W   = 2;
	localparam int SEQ_OUT_W = 64;
	localparam int CNT_OUT_W = 32;

	// Frame phase codes, also reported on the phase port
	localparam logic [PHASE_W-1:0] PH_SEQ = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LEN = 2'd1;
	localparam logic [PHASE_W-1:0] PH_PAY = 2'd2;

endpackage

/* sv/length_prefixed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Splits a byte stream into frames of sequence header, length header and
// payload, and reports the role and progress of every byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and returns one result per byte, with
// no gaps as long as out_ready stays high. Each byte passes an input register
// (data_s1), where the frame state is advanced in one short step (insert the
// byte into a header field, or count one payload byte down), and then lands in
// the output register; a byte's result shows on the outputs when it leaves
// data_s1, which happens once the output slot is free or draining. The
// input register takes one more byte while a result waits on a stalled
// output, then holds. A frame is HEADER_FIELD_BYTES of little-endian sequence
// number, HEADER_FIELD_BYTES of little-endian payload length, then that many
// payload bytes. Lengths above the LENGTH_BITS counter saturate to its
// maximum and raise length_clamped; frame_length and bytes_wanted show the low
// 32 bits of the saturated value. A zero length ends the frame on the last
// length byte. frame_done marks the byte that completes a frame, and the next
// byte starts a new frame.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_receiver_macros.svh"

module length_prefixed_frame_receiver #(
	parameter int HEADER_FIELD_BYTES = lpfr_pkg::HEADER_FIELD_BYTES_DEF,
	parameter int LENGTH_BITS        = lpfr_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [lpfr_pkg::BYTE_W-1:0]           data_byte,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [lpfr_pkg::PHASE_W-1:0]          phase,
	output logic [lpfr_pkg::BYTE_W-1:0]           payload_byte,
	output logic                                  payload_valid,
	output logic [lpfr_pkg::SEQ_OUT_W-1:0]        sequence_number,
	output logic [lpfr_pkg::CNT_OUT_W-1:0]        frame_length,
	output logic [lpfr_pkg::CNT_OUT_W-1:0]        bytes_wanted,
	output logic                                  frame_done,
	output logic                                  length_clamped
);

	localparam int HDR_W = lpfr_pkg::BYTE_W * HEADER_FIELD_BYTES;
	localparam int IDX_W = (HEADER_FIELD_BYTES > 1) ? $clog2(HEADER_FIELD_BYTES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HEADER_FIELD_BYTES - 1);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [lpfr_pkg::CNT_OUT_W-1:0] LEN_MAX_OUT = lpfr_pkg::CNT_OUT_W'(LEN_MAX);

	// Input register
	logic                          valid_s1;
	logic [lpfr_pkg::BYTE_W-1:0]   data_s1;

	// Frame state
	logic [lpfr_pkg::PHASE_W-1:0]  phase_q;
	logic [IDX_W-1:0]              idx_q;
	logic [HDR_W-1:0]              seq_q;
	logic [HDR_W-1:0]              len_q;
	logic [LENGTH_BITS-1:0]        eff_q;
	logic                          clamp_q;
	logic [LENGTH_BITS-1:0]        remain_q;

	// Result register
	logic                          valid_s2;
	logic [lpfr_pkg::PHASE_W-1:0]  phase_s2;
	logic [lpfr_pkg::BYTE_W-1:0]   pbyte_s2;
	logic                          pvalid_s2;
	logic [lpfr_pkg::SEQ_OUT_W-1:0] seq_s2;
	logic [lpfr_pkg::CNT_OUT_W-1:0] flen_s2;
	logic [lpfr_pkg::CNT_OUT_W-1:0] wanted_s2;
	logic                          done_s2;
	logic                          clamped_s2;

	// Next-state and result logic
	logic                          advance;
	logic                          idx_last;
	logic [lpfr_pkg::PHASE_W-1:0]  phase_d;
	logic [IDX_W-1:0]              idx_d;
	logic [HDR_W-1:0]              seq_d;
	logic [HDR_W-1:0]              len_d;
	logic                          clamp_d;
	logic [LENGTH_BITS-1:0]        eff_d;
	logic [LENGTH_BITS-1:0]        remain_d;
	logic [lpfr_pkg::PHASE_W-1:0]  role;
	logic                          pvalid;
	logic [lpfr_pkg::CNT_OUT_W-1:0] wanted;
	logic                          done;
	logic                          len_known;

	// Move s1 into the result register whenever that slot is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign idx_last = (idx_q == IDX_LAST);

	// Assemble the length field; the first byte of a frame clears it
	always_comb begin
		len_d = len_q;
		if (phase_q == lpfr_pkg::PH_SEQ) begin
			if (idx_q == '0) begin
				len_d = '0;
			end
		end else if (phase_q == lpfr_pkg::PH_LEN) begin
			for (int k = 0; k < HEADER_FIELD_BYTES; k++) begin
				if (IDX_W'(k) == idx_q) begin
					len_d[lpfr_pkg::BYTE_W*k +: lpfr_pkg::BYTE_W] = data_s1;
				end
			end
		end
	end

	// Saturate the assembled length against the counter range
	always_comb begin
		clamp_d = ((lpfr_pkg::SEQ_OUT_W'(len_d) >> LENGTH_BITS) != '0);
		eff_d   = clamp_d ? LEN_MAX : LENGTH_BITS'(len_d);
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_last ? '0 : idx_q + 1'b1;
		seq_d     = seq_q;
		remain_d  = remain_q;
		role      = lpfr_pkg::PH_PAY;
		pvalid    = 1'b0;
		wanted    = '0;
		done      = 1'b0;
		len_known = 1'b0;
		case (phase_q)
			lpfr_pkg::PH_SEQ: begin
				role = lpfr_pkg::PH_SEQ;
				// first byte of a frame clears the previous sequence
				if (idx_q == '0) begin
					seq_d = '0;
				end
				for (int k = 0; k < HEADER_FIELD_BYTES; k++) begin
					if (IDX_W'(k) == idx_q) begin
						seq_d[lpfr_pkg::BYTE_W*k +: lpfr_pkg::BYTE_W] = data_s1;
					end
				end
				if (idx_last) begin
					phase_d = lpfr_pkg::PH_LEN;
					wanted  = lpfr_pkg::CNT_OUT_W'(HEADER_FIELD_BYTES);
				end else begin
					wanted  = lpfr_pkg::CNT_OUT_W'(IDX_LAST - idx_q);
				end
			end
			lpfr_pkg::PH_LEN: begin
				role = lpfr_pkg::PH_LEN;
				if (idx_last) begin
					len_known = 1'b1;
					remain_d  = eff_d;
					wanted    = lpfr_pkg::CNT_OUT_W'(eff_d);
					if (eff_d == '0) begin
						done    = 1'b1;
						phase_d = lpfr_pkg::PH_SEQ;
					end else begin
						phase_d = lpfr_pkg::PH_PAY;
					end
				end else begin
					wanted = lpfr_pkg::CNT_OUT_W'(IDX_LAST - idx_q);
				end
			end
			default: begin
				// payload; count one byte down, never below zero
				len_known = 1'b1;
				pvalid    = 1'b1;
				idx_d     = '0;
				if (remain_q != '0) begin
					remain_d = remain_q - 1'b1;
				end
				wanted = lpfr_pkg::CNT_OUT_W'(remain_d);
				if (remain_d == '0) begin
					done    = 1'b1;
					phase_d = lpfr_pkg::PH_SEQ;
				end
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	// Frame state, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lpfr_pkg::PH_SEQ;
			idx_q    <= '0;
			seq_q    <= '0;
			len_q    <= '0;
			eff_q    <= '0;
			clamp_q  <= 1'b0;
			remain_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			if (phase_q == lpfr_pkg::PH_LEN && idx_last) begin
				eff_q   <= eff_d;
				clamp_q <= clamp_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2   <= role;
			pbyte_s2   <= pvalid ? data_s1 : '0;
			pvalid_s2  <= pvalid;
			seq_s2     <= lpfr_pkg::SEQ_OUT_W'(seq_d);
			wanted_s2  <= wanted;
			done_s2    <= done;
			if (!len_known) begin
				flen_s2    <= '0;
				clamped_s2 <= 1'b0;
			end else if (phase_q == lpfr_pkg::PH_LEN) begin
				flen_s2    <= lpfr_pkg::CNT_OUT_W'(eff_d);
				clamped_s2 <= clamp_d;
			end else begin
				flen_s2    <= lpfr_pkg::CNT_OUT_W'(eff_q);
				clamped_s2 <= clamp_q;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign phase           = phase_s2;
	assign payload_byte    = pbyte_s2;
	assign payload_valid   = pvalid_s2;
	assign sequence_number = seq_s2;
	assign frame_length    = flen_s2;
	assign bytes_wanted    = wanted_s2;
	assign frame_done      = done_s2;
	assign length_clamped  = clamped_s2;

	// A payload phase always has at least one byte left to take
	`LPFR_ASSERT(a_pay_remain, clk, arst_n, (phase_q == lpfr_pkg::PH_PAY) |-> (remain_q != '0))
	// The byte that closes a frame wants nothing more
	`LPFR_ASSERT(a_done_zero, clk, arst_n, (valid_s2 && done_s2) |-> (wanted_s2 == '0))
	// A clamped length always reads as the counter maximum
	`LPFR_ASSERT(a_clamp_max, clk, arst_n, (valid_s2 && clamped_s2) |-> (flen_s2 == LEN_MAX_OUT))
	// The header index never runs past the field
	`LPFR_NEVER(a_idx_range, clk, arst_n, idx_q > IDX_LAST)

endmodule

/* tb/length_prefixed_frame_receiver_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_tb
// Self-checking bench for the frame receiver. It walks a short table of
// directed bytes, then random well-formed frames. The last frame carries an
// oversized length. Both channels see random idle and stall bursts. Every
// result is compared field by field with a cycle-free model of the deframer.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR = lpfr_pkg::HEADER_FIELD_BYTES_DEF;
	localparam logic [63:0] LEN_CAP = (lpfr_pkg::LENGTH_BITS_DEF >= 64) ? '1 :
		((64'd1 << lpfr_pkg::LENGTH_BITS_DEF) - 64'd1);
	localparam int RANDOM_ITEMS   = 600;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_PAYLOAD   = 24;

	// One report per accepted byte, in port order
	typedef struct packed {
		logic [lpfr_pkg::PHASE_W-1:0]   role;
		logic [lpfr_pkg::BYTE_W-1:0]    pay_byte;
		logic                           pay_valid;
		logic [lpfr_pkg::SEQ_OUT_W-1:0] seq_num;
		logic [lpfr_pkg::CNT_OUT_W-1:0] frame_len;
		logic [lpfr_pkg::CNT_OUT_W-1:0] wanted;
		logic                           done;
		logic                           clamped;
	} byte_report_t;

	typedef struct packed {
		logic [lpfr_pkg::BYTE_W-1:0] data;
		logic                        typed;
		byte_report_t                report;
	} stim_row_t;

	// Zero-length frame with an all-ones sequence number. Rows with the typed
	// bit carry a report read straight off the frame layout; the rest use the
	// model.
	localparam int DIR_ROWS = 16;
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		// first byte after reset: lowest sequence byte, seven still wanted
		'{8'hFF, 1'b1, '{lpfr_pkg::PH_SEQ, 8'h00, 1'b0, 64'h0000_0000_0000_00FF,
			32'd0, 32'd7, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		// sequence complete: whole length field wanted next
		'{8'hFF, 1'b1, '{lpfr_pkg::PH_SEQ, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			32'd0, 32'd8, 1'b0, 1'b0}},
		'{8'h00, 1'b1, '{lpfr_pkg::PH_LEN, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			32'd0, 32'd7, 1'b0, 1'b0}},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		// zero length: the frame ends on its last length byte
		'{8'h00, 1'b1, '{lpfr_pkg::PH_LEN, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			32'd0, 32'd0, 1'b1, 1'b0}}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [lpfr_pkg::BYTE_W-1:0]    data_byte;
	logic                           out_valid;
	logic                           out_ready;
	logic [lpfr_pkg::PHASE_W-1:0]   phase;
	logic [lpfr_pkg::BYTE_W-1:0]    payload_byte;
	logic                           payload_valid;
	logic [lpfr_pkg::SEQ_OUT_W-1:0] sequence_number;
	logic [lpfr_pkg::CNT_OUT_W-1:0] frame_length;
	logic [lpfr_pkg::CNT_OUT_W-1:0] bytes_wanted;
	logic                           frame_done;
	logic                           length_clamped;

	// Typed expectation travels with the byte on the input channel
	logic         row_typed;
	byte_report_t row_report;

	// Deframer model state, reset values
	logic [lpfr_pkg::PHASE_W-1:0] track_phase = lpfr_pkg::PH_SEQ;
	int unsigned        track_idx   = 0;
	logic [63:0]        track_seq   = '0;
	logic [63:0]        track_len   = '0;
	logic [63:0]        track_count = '0;

	byte_report_t expected_reports [$];

	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned issued    = 0;
	int unsigned mismatches = 0;
	int unsigned accepted_bytes = 0;
	int unsigned reports_seen   = 0;
	int unsigned frames_closed  = 0;
	int unsigned payload_seen   = 0;
	int unsigned clamped_seen   = 0;

	length_prefixed_frame_receiver u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.phase           (phase),
		.payload_byte    (payload_byte),
		.payload_valid   (payload_valid),
		.sequence_number (sequence_number),
		.frame_length    (frame_length),
		.bytes_wanted    (bytes_wanted),
		.frame_done      (frame_done),
		.length_clamped  (length_clamped)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hold reset once at the start, then release it
	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Advance the model by one byte and return the report it causes
	function automatic void deframe_byte(input logic [lpfr_pkg::BYTE_W-1:0] b,
			output byte_report_t r);
		logic [63:0] eff;
		logic [63:0] rem;
		logic        known;
		int unsigned idx;
		r = '0;
		known = 1'b0;
		idx = track_idx & 7;
		eff = (track_len > LEN_CAP) ? LEN_CAP : track_len;
		case (track_phase)
		lpfr_pkg::PH_SEQ: begin
			r.role = lpfr_pkg::PH_SEQ;
			// first sequence byte opens a new frame: clear everything
			if (idx == 0) begin
				track_seq = '0;
				track_len = '0;
				track_count = '0;
			end
			track_seq = track_seq | ({56'd0, b} << (8 * idx));
			idx++;
			if (idx >= HDR) begin
				track_phase = lpfr_pkg::PH_LEN;
				track_idx = 0;
				r.wanted = 32'(HDR);
			end else begin
				track_idx = idx;
				r.wanted = 32'(HDR - idx);
			end
		end
		lpfr_pkg::PH_LEN: begin
			r.role = lpfr_pkg::PH_LEN;
			track_len = track_len | ({56'd0, b} << (8 * idx));
			idx++;
			if (idx >= HDR) begin
				eff = (track_len > LEN_CAP) ? LEN_CAP : track_len;
				track_idx = 0;
				track_count = '0;
				known = 1'b1;
				if (eff == 0) begin
					r.done = 1'b1;
					track_phase = lpfr_pkg::PH_SEQ;
				end else begin
					track_phase = lpfr_pkg::PH_PAY;
					r.wanted = eff[31:0];
				end
			end else begin
				track_idx = idx;
				r.wanted = 32'(HDR - idx);
			end
		end
		default: begin
			// payload, and the unused phase code as well
			r.role = lpfr_pkg::PH_PAY;
			known = 1'b1;
			r.pay_byte = b;
			r.pay_valid = 1'b1;
			if (track_count < eff)
				track_count++;
			rem = eff - track_count;
			r.wanted = rem[31:0];
			if (track_count >= eff) begin
				r.done = 1'b1;
				track_phase = lpfr_pkg::PH_SEQ;
				track_idx = 0;
			end
		end
		endcase
		eff = (track_len > LEN_CAP) ? LEN_CAP : track_len;
		r.seq_num = track_seq;
		r.frame_len = known ? eff[31:0] : '0;
		r.clamped = known && (track_len > LEN_CAP);
	endfunction

	// Offer one byte, after an optional idle burst, and hold it until taken
	task automatic send_byte(input logic [lpfr_pkg::BYTE_W-1:0] b, input logic typed,
			input byte_report_t rep);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		row_typed <= typed;
		row_report <= rep;
		issued++;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stall the result channel in random bursts
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Predict on every accepted byte, check on every accepted result
	always @(posedge clk) begin : scoreboard
		byte_report_t pred;
		byte_report_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_byte(data_byte, pred);
				expected_reports.push_back(row_typed ? row_report : pred);
				accepted_bytes++;
			end
			if (out_valid && out_ready) begin
				reports_seen++;
				if (frame_done)
					frames_closed++;
				if (payload_valid)
					payload_seen++;
				if (length_clamped)
					clamped_seen++;
				if (expected_reports.size() == 0) begin
					$error("result with no byte pending: phase %0d", phase);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (phase !== want.role) begin
						$error("phase: expected %0d, got %0d", want.role, phase);
						mismatches++;
					end
					if (payload_byte !== want.pay_byte) begin
						$error("payload_byte: expected %0h, got %0h",
							want.pay_byte, payload_byte);
						mismatches++;
					end
					if (payload_valid !== want.pay_valid) begin
						$error("payload_valid: expected %0d, got %0d",
							want.pay_valid, payload_valid);
						mismatches++;
					end
					if (sequence_number !== want.seq_num) begin
						$error("sequence_number: expected %0h, got %0h",
							want.seq_num, sequence_number);
						mismatches++;
					end
					if (frame_length !== want.frame_len) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_len, frame_length);
						mismatches++;
					end
					if (bytes_wanted !== want.wanted) begin
						$error("bytes_wanted: expected %0d, got %0d",
							want.wanted, bytes_wanted);
						mismatches++;
					end
					if (frame_done !== want.done) begin
						$error("frame_done: expected %0d, got %0d",
							want.done, frame_done);
						mismatches++;
					end
					if (length_clamped !== want.clamped) begin
						$error("length_clamped: expected %0d, got %0d",
							want.clamped, length_clamped);
						mismatches++;
					end
				end
			end
		end
	end

	// End the run when neither channel moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL length_prefixed_frame_receiver");
		$finish;
	end

	initial begin : stimulus
		int unsigned i;
		int unsigned k;
		int unsigned pick;
		int unsigned frame_cnt;
		logic [63:0] seq_val;
		logic [63:0] len_val;
		in_valid <= 1'b0;
		data_byte <= '0;
		row_typed <= 1'b0;
		row_report <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed table: no idling, so the first bytes land back to back
		for (i = 0; i < DIR_ROWS; i++)
			send_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].report);

		// Random well-formed frames with short payloads, a few long ones
		frame_cnt = 0;
		while (issued < RANDOM_ITEMS) begin
			// quiet stretch near the end, and now and then in the middle
			if (issued > RANDOM_ITEMS - 120 || $urandom_range(0, 3) == 0) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(5, 35);
				stall_pct = $urandom_range(5, 35);
			end
			// drain everything before the next frame now and then
			if (frame_cnt % 7 == 3) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_reports.size() != 0) @(posedge clk);
			end

			pick = $urandom_range(0, 9);
			if (pick == 0)
				seq_val = '0;
			else if (pick == 1)
				seq_val = '1;
			else
				seq_val = {$urandom(), $urandom()};

			pick = $urandom_range(0, 99);
			if (pick < 12)
				len_val = '0;
			else if (pick < 16)
				len_val = 64'($urandom_range(128, 255));
			else
				len_val = 64'($urandom_range(1, 12));

			for (k = 0; k < HDR; k++)
				send_byte(seq_val[8*k +: 8], 1'b0, '0);
			for (k = 0; k < HDR; k++)
				send_byte(len_val[8*k +: 8], 1'b0, '0);
			for (k = 0; k < len_val; k++)
				send_byte(lpfr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
			frame_cnt++;
		end

		// Oversized length last: it saturates and the frame never closes
		gap_pct = 0;
		stall_pct = 0;
		seq_val = {$urandom(), $urandom()};
		for (k = 0; k < HDR; k++)
			send_byte(seq_val[8*k +: 8], 1'b0, '0);
		for (k = 0; k < HDR; k++)
			send_byte(8'hFF, 1'b0, '0);
		for (k = 0; k < TAIL_PAYLOAD; k++)
			send_byte(lpfr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
		in_valid <= 1'b0;
		@(posedge clk);

		// Drain, then keep watching for a stray result before the verdict
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes in %0d random frames plus directed and tail frames,",
			accepted_bytes, frame_cnt);
		$display("%0d results checked: %0d frames closed, %0d payload bytes, %0d clamped.",
			reports_seen, frames_closed, payload_seen, clamped_seen);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("PASS length_prefixed_frame_receiver");
		end else begin
			$display("FAIL length_prefixed_frame_receiver");
		end
		$finish;
	end

endmodule
